>>> hw/rtl/triangle_edge_coverage_test_top_macros.svh
// Assertion macros for the triangle edge coverage block.
// Used by triangle_edge_coverage_test_top; no other dependencies.
`ifndef TRIANGLE_EDGE_COVERAGE_TEST_TOP_MACROS_SVH
`define TRIANGLE_EDGE_COVERAGE_TEST_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define TECT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TECT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tect_pkg.sv
// Package for the triangle edge coverage block: widths, limits and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tect_pkg;

  localparam int NumVert   = 3;
  localparam int IdxW      = 2;
  localparam int CoordW    = 16;
  localparam int WeightW   = 18;
  localparam int BaryW     = 18;
  localparam int FracBits  = 16;
  localparam int InDataW   = 88;
  localparam int OutDataW  = 56;

  localparam int DiffW = CoordW + 1;         // vertex and point differences
  localparam int ProdW = 2 * DiffW;          // dx*uy, dy*ux
  localparam int EdgeW = ProdW + 1;          // edge function value
  localparam int EwW   = EdgeW + WeightW + 1; // weighted edge value
  localparam int SumW  = EwW + 2;            // sum of three weighted values

  localparam logic [WeightW-1:0] OneQ16 = WeightW'(65536);
  localparam logic signed [BaryW-1:0] BaryMax = BaryW'(131071);
  localparam logic signed [BaryW-1:0] BaryMin = BaryW'(-131072);

  localparam logic KindVertex = 1'b0;
  localparam logic KindPixel  = 1'b1;

endpackage
`default_nettype wire

>>> hw/rtl/triangle_edge_coverage_test_top.sv
// Triangle edge coverage top level: vertex store, edge evaluation and
// pipelined barycentric divider. Depends on tect_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_edge_coverage_test_top_macros.svh"

// Takes one item per cycle unless the output stalls. A vertex item (tuser = 0)
// with index 0 to 2 writes one vertex at acceptance and yields no result; a pixel
// item accepted in the next cycle already sees it. A pixel item yields one result
// after six stages of edge evaluation, weighting and summing, then 17 stages of a
// restoring divider (one quotient bit per stage, three lanes), then the
// output register. The whole pipeline moves whenever the output register is
// empty or being taken.
module triangle_edge_coverage_test_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [1:0] vertex_index, [17:2] vertex_x, [33:18] vertex_y, [51:34] vertex_w,
  // [67:52] pixel_x, [83:68] pixel_y, rest zero
  input  wire  [tect_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] kind
  input  wire                             s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // [0] inside_res, [18:1] bary_0, [36:19] bary_1, [54:37] bary_2, [55] zero_sum
  output logic [tect_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import tect_pkg::*;

  localparam int DivSteps = FracBits + 1;

  // vertex store
  logic signed [CoordW-1:0]  vx_q [NumVert];
  logic signed [CoordW-1:0]  vy_q [NumVert];
  logic        [WeightW-1:0] vw_q [NumVert];

  logic adv, acc;
  logic [IdxW-1:0]          in_idx;
  logic signed [CoordW-1:0] in_vx, in_vy, in_px, in_py;
  logic [WeightW-1:0]       in_vw;

  assign in_idx = s_axis_tdata_i[1:0];
  assign in_vx  = s_axis_tdata_i[17:2];
  assign in_vy  = s_axis_tdata_i[33:18];
  assign in_vw  = s_axis_tdata_i[51:34];
  assign in_px  = s_axis_tdata_i[67:52];
  assign in_py  = s_axis_tdata_i[83:68];

  assign adv             = m_axis_tready_i | ~m_axis_tvalid_o;
  assign s_axis_tready_o = adv;
  assign acc             = s_axis_tvalid_i & adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumVert; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
        vw_q[i] <= OneQ16;
      end
    end else if (acc && s_axis_tuser_i == KindVertex && in_idx < IdxW'(NumVert)) begin
      vx_q[in_idx] <= in_vx;
      vy_q[in_idx] <= in_vy;
      vw_q[in_idx] <= in_vw;
    end
  end

  // stage 1: differences and edge flags
  logic                      v1_q;
  logic signed [DiffW-1:0]   dx_d [NumVert], dy_d [NumVert], ux_d [NumVert], uy_d [NumVert];
  logic signed [DiffW-1:0]   dx_q [NumVert], dy_q [NumVert], ux_q [NumVert], uy_q [NumVert];
  logic [WeightW-1:0]        w1_q [NumVert];
  logic [NumVert-1:0]        tl_d, tl1_q;

  always_comb begin
    for (int e = 0; e < NumVert; e++) begin
      // edge e runs from vertex e+1 to vertex e+2
      dx_d[e] = DiffW'(vx_q[(e + 2) % NumVert]) - DiffW'(vx_q[(e + 1) % NumVert]);
      dy_d[e] = DiffW'(vy_q[(e + 2) % NumVert]) - DiffW'(vy_q[(e + 1) % NumVert]);
      ux_d[e] = DiffW'(in_px) - DiffW'(vx_q[(e + 1) % NumVert]);
      uy_d[e] = DiffW'(in_py) - DiffW'(vy_q[(e + 1) % NumVert]);
      tl_d[e] = ((dy_d[e] == '0) && dx_d[e][DiffW-1]) || dy_d[e][DiffW-1];
    end
  end

  // stage 2: products
  logic                    v2_q;
  logic signed [ProdW-1:0] p1_q [NumVert], p2_q [NumVert];
  logic [WeightW-1:0]      w2_q [NumVert];
  logic [NumVert-1:0]      tl2_q;

  // stage 3: edge values
  logic                    v3_q;
  logic signed [EdgeW-1:0] e3_q [NumVert];
  logic [WeightW-1:0]      w3_q [NumVert];
  logic [NumVert-1:0]      tl3_q;

  // stage 4: weighted values and coverage
  logic                    v4_q, in4_q, in4_d;
  logic signed [EwW-1:0]   ew4_q [NumVert];

  always_comb begin
    logic any_neg, all_pos, edge_hit;
    any_neg  = 1'b0;
    all_pos  = 1'b1;
    edge_hit = 1'b0;
    for (int e = 0; e < NumVert; e++) begin
      any_neg  = any_neg | e3_q[e][EdgeW-1];
      all_pos  = all_pos & ~e3_q[e][EdgeW-1] & (e3_q[e] != '0);
      edge_hit = edge_hit | ((e3_q[e] == '0) & tl3_q[e]);
    end
    in4_d = ~any_neg & (all_pos | edge_hit);
  end

  // stage 5: sum and magnitudes
  logic                    v5_q, in5_q;
  logic signed [SumW-1:0]  sum5_q;
  logic [SumW-1:0]         ne5_q [NumVert];
  logic [NumVert-1:0]      neg5_q;

  // stage 6: divisor magnitude, signs, zero flag
  logic                    v6_q, in6_q, z6_q;
  logic [SumW-1:0]         ns6_q, ne6_q [NumVert];
  logic [NumVert-1:0]      neg6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc && s_axis_tuser_i == KindPixel;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < NumVert; e++) begin
        dx_q[e] <= dx_d[e]; dy_q[e] <= dy_d[e];
        ux_q[e] <= ux_d[e]; uy_q[e] <= uy_d[e];
        w1_q[e] <= vw_q[e];
        p1_q[e] <= dx_q[e] * uy_q[e];
        p2_q[e] <= dy_q[e] * ux_q[e];
        w2_q[e] <= w1_q[e];
        e3_q[e] <= EdgeW'(p1_q[e]) - EdgeW'(p2_q[e]);
        w3_q[e] <= w2_q[e];
        ew4_q[e] <= EwW'(e3_q[e]) * $signed({1'b0, w3_q[e]});
        neg5_q[e] <= ew4_q[e][EwW-1];
        ne5_q[e] <= ew4_q[e][EwW-1] ? SumW'(-ew4_q[e]) : SumW'(ew4_q[e]);
        ne6_q[e] <= ne5_q[e];
        neg6_q[e] <= neg5_q[e] ^ sum5_q[SumW-1];
      end
      tl1_q  <= tl_d;
      tl2_q  <= tl1_q;
      tl3_q  <= tl2_q;
      in4_q  <= in4_d;
      in5_q  <= in4_q;
      sum5_q <= SumW'(ew4_q[0]) + SumW'(ew4_q[1]) + SumW'(ew4_q[2]);
      in6_q  <= in5_q;
      ns6_q  <= sum5_q[SumW-1] ? SumW'(-sum5_q) : SumW'(sum5_q);
      z6_q   <= sum5_q == '0;
    end
  end

  // divider stages: stage 0 takes the integer bit and the saturation check
  logic                    vd_q  [DivSteps];
  logic [SumW-1:0]         rem_q [DivSteps][NumVert];
  logic [DivSteps-1:0]     quo_q [DivSteps][NumVert];
  logic [NumVert-1:0]      sat_q [DivSteps];
  logic [NumVert-1:0]      negd_q[DivSteps];
  logic [SumW-1:0]         nsd_q [DivSteps];
  logic                    ind_q [DivSteps];
  logic                    zd_q  [DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivSteps; s++) vd_q[s] <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= v6_q;
      for (int s = 1; s < DivSteps; s++) vd_q[s] <= vd_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SumW:0] t;
    if (adv) begin
      for (int e = 0; e < NumVert; e++) begin
        sat_q[0][e] <= {1'b0, ne6_q[e]} >= {ns6_q, 1'b0};
        if (ne6_q[e] >= ns6_q) begin
          rem_q[0][e] <= ne6_q[e] - ns6_q;
          quo_q[0][e] <= DivSteps'(1);
        end else begin
          rem_q[0][e] <= ne6_q[e];
          quo_q[0][e] <= '0;
        end
      end
      negd_q[0] <= neg6_q;
      nsd_q[0]  <= ns6_q;
      ind_q[0]  <= in6_q;
      zd_q[0]   <= z6_q;
      for (int s = 1; s < DivSteps; s++) begin
        for (int e = 0; e < NumVert; e++) begin
          t = {rem_q[s-1][e], 1'b0};
          if (t >= {1'b0, nsd_q[s-1]}) begin
            rem_q[s][e] <= SumW'(t - {1'b0, nsd_q[s-1]});
            quo_q[s][e] <= {quo_q[s-1][e][DivSteps-2:0], 1'b1};
          end else begin
            rem_q[s][e] <= SumW'(t);
            quo_q[s][e] <= {quo_q[s-1][e][DivSteps-2:0], 1'b0};
          end
        end
        sat_q[s]  <= sat_q[s-1];
        negd_q[s] <= negd_q[s-1];
        nsd_q[s]  <= nsd_q[s-1];
        ind_q[s]  <= ind_q[s-1];
        zd_q[s]   <= zd_q[s-1];
      end
    end
  end

  // output register
  logic signed [BaryW-1:0] bary_d [NumVert];
  logic signed [BaryW-1:0] bary_q [NumVert];
  logic                    inside_q, zero_q, vo_q;

  always_comb begin
    for (int e = 0; e < NumVert; e++) begin
      if (zd_q[DivSteps-1]) begin
        bary_d[e] = '0;
      end else if (sat_q[DivSteps-1][e]) begin
        bary_d[e] = negd_q[DivSteps-1][e] ? BaryMin : BaryMax;
      end else if (negd_q[DivSteps-1][e]) begin
        bary_d[e] = -BaryW'(quo_q[DivSteps-1][e]);
      end else begin
        bary_d[e] = BaryW'(quo_q[DivSteps-1][e]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= vd_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int e = 0; e < NumVert; e++) bary_q[e] <= bary_d[e];
      inside_q <= ind_q[DivSteps-1];
      zero_q   <= zd_q[DivSteps-1];
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {zero_q, bary_q[2], bary_q[1], bary_q[0], inside_q};

  `TECT_ASSERT_IMP(a_zero_sum_weights, vo_q && zero_q,
    bary_q[0] == '0 && bary_q[1] == '0 && bary_q[2] == '0, "zero sum with nonzero weight")
  `TECT_ASSERT_NXT(a_stall_holds, !adv, $stable(vd_q[DivSteps-1]) && $stable(v6_q),
    "pipeline moved while stalled")
  `TECT_ASSERT_NXT(a_vertex_write,
    acc && s_axis_tuser_i == KindVertex && in_idx == '0,
    vx_q[0] == $past(in_vx) && vw_q[0] == $past(in_vw), "vertex store not written")
  `TECT_ASSERT_IMP(a_sat_positive, vo_q && !zero_q && bary_q[0] == BaryMax,
    !m_axis_tdata_o[OutDataW-1], "saturated weight with zero flag")

endmodule
`default_nettype wire

>>> dv/tb_triangle_edge_coverage_test_top.sv
// Testbench for triangle_edge_coverage_test_top: vertex loads and pixel tests,
// with a local coverage and barycentric predictor. Depends on tect_pkg.
`timescale 1ns / 1ps

module tb_triangle_edge_coverage_test_top;
  import tect_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [87:0] data;
  } item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  triangle_edge_coverage_test_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t               pending_items[$];
  logic [OutDataW-1:0] expected_results[$];
  int                  errors = 0;
  int                  cycles = 0;
  int                  send_gap = 0;
  int                  recv_gap = 0;
  bit                  stim_done = 0;
  bit                  in_taken = 0;

  // triangle state
  longint vx[3], vy[3], vw[3], ea[3], eb[3], ec[3];
  bit     top_f[3], left_f[3];

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void build_edge(int e, int f, int t);
    longint dx, dy;
    dx = vx[t] - vx[f];
    dy = vy[t] - vy[f];
    ea[e] = -dy;
    eb[e] = dx;
    ec[e] = dy * vx[f] - dx * vy[f];
    top_f[e] = (ea[e] == 0) && (eb[e] < 0);
    left_f[e] = ea[e] > 0;
  endfunction

  function automatic longint bary_div(longint e, longint s);
    longint ne, ns, ip, rem, q;
    bit neg;
    ne = e < 0 ? -e : e;
    ns = s < 0 ? -s : s;
    neg = (e < 0) != (s < 0);
    ip = ne / ns;
    rem = ne % ns;
    if (ip >= 2) return neg ? -131072 : 131071;
    q = ip;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= ns) begin
        rem = rem - ns;
        q = q | 1;
      end
    end
    return neg ? -q : q;
  endfunction

  function automatic void predict_coverage(item_t it);
    longint px, py, sum, b;
    longint r[3], ew[3];
    bit in_f;
    logic [OutDataW-1:0] res;
    if (it.kind == KindVertex) begin
      if (it.data[1:0] < 3) begin
        vx[it.data[1:0]] = longint'($signed(it.data[17:2]));
        vy[it.data[1:0]] = longint'($signed(it.data[33:18]));
        vw[it.data[1:0]] = longint'(it.data[51:34]);
        build_edge(2, 0, 1);
        build_edge(0, 1, 2);
        build_edge(1, 2, 0);
      end
      return;
    end
    px = longint'($signed(it.data[67:52]));
    py = longint'($signed(it.data[83:68]));
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = ea[i] * px + eb[i] * py + ec[i];
      ew[i] = r[i] * vw[i];
      sum += ew[i];
    end
    in_f = 0;
    if (r[0] < 0 || r[1] < 0 || r[2] < 0) in_f = 0;
    else if (r[0] > 0 && r[1] > 0 && r[2] > 0) in_f = 1;
    else
      for (int i = 0; i < 3; i++)
        if (r[i] == 0 && (top_f[i] || left_f[i])) in_f = 1;
    res = '0;
    res[0] = in_f;
    for (int i = 0; i < 3; i++) begin
      b = (sum == 0) ? 0 : bary_div(ew[i], sum);
      res[1 + 18 * i +: 18] = b[17:0];
    end
    res[55] = (sum == 0);
    expected_results.push_back(res);
  endfunction

  function automatic item_t mk_vertex(int idx, int x, int y, int w);
    item_t it;
    it.kind = KindVertex;
    it.data = '0;
    it.data[1:0] = idx[1:0];
    it.data[17:2] = x[15:0];
    it.data[33:18] = y[15:0];
    it.data[51:34] = w[17:0];
    return it;
  endfunction

  function automatic item_t mk_pixel(int x, int y);
    item_t it;
    logic [63:0] junk;
    it.kind = KindPixel;
    it.data = '0;
    it.data[67:52] = x[15:0];
    it.data[83:68] = y[15:0];
    // junk in vertex fields is ignored by pixel items
    junk = {$urandom, $urandom};
    it.data[51:0] = junk[51:0];
    return it;
  endfunction

  function automatic int rnd_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic report_mismatch(string what, logic [OutDataW-1:0] got,
                                 logic [OutDataW-1:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  initial begin
    int x0, y0, sp;
    for (int i = 0; i < 3; i++) begin
      vx[i] = 0; vy[i] = 0; vw[i] = 65536;
      ea[i] = 0; eb[i] = 0; ec[i] = 0; top_f[i] = 0; left_f[i] = 0;
    end
    // directed: reset state, degenerate, extremes, edges on the grid
    pending_items.push_back(mk_pixel(0, 0));
    pending_items.push_back(mk_vertex(0, 0, 0, 65536));
    pending_items.push_back(mk_vertex(1, 160, 0, 65536));
    pending_items.push_back(mk_vertex(2, 0, 160, 65536));
    pending_items.push_back(mk_pixel(16, 16));
    pending_items.push_back(mk_pixel(0, 0));
    pending_items.push_back(mk_pixel(80, 0));
    pending_items.push_back(mk_pixel(0, 80));
    pending_items.push_back(mk_pixel(80, 80));
    pending_items.push_back(mk_pixel(-16, 16));
    pending_items.push_back(mk_pixel(400, 400));
    pending_items.push_back(mk_vertex(3, 5, 5, 5));
    pending_items.push_back(mk_vertex(1, 0, 160, 65536));
    pending_items.push_back(mk_vertex(2, 160, 0, 65536));
    pending_items.push_back(mk_pixel(16, 16));
    pending_items.push_back(mk_pixel(0, 80));
    pending_items.push_back(mk_vertex(0, -32768, -32768, 262143));
    pending_items.push_back(mk_vertex(1, 32767, -32768, 0));
    pending_items.push_back(mk_vertex(2, -32768, 32767, 1));
    pending_items.push_back(mk_pixel(32767, 32767));
    pending_items.push_back(mk_pixel(-32768, -32768));
    pending_items.push_back(mk_pixel(0, 0));
    pending_items.push_back(mk_vertex(0, 0, 0, 0));
    pending_items.push_back(mk_vertex(1, 0, 0, 0));
    pending_items.push_back(mk_pixel(0, 0));
    // random: mostly triangles with a burst of nearby samples
    while (pending_items.size() < 675) begin
      sp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(16, 800);
      x0 = rnd_coord(32767 - sp);
      y0 = rnd_coord(32767 - sp);
      for (int v = 0; v < 3; v++)
        if ($urandom_range(0, 4) != 0)
          pending_items.push_back(mk_vertex(($urandom_range(0, 19) == 0) ? 3 : v,
            x0 + rnd_coord(sp) / 16 * (($urandom_range(0, 1)) ? 16 : 1),
            y0 + rnd_coord(sp) / 16 * (($urandom_range(0, 1)) ? 16 : 1),
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 262143) :
            ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(16384, 98304)));
      repeat ($urandom_range(4, 14)) begin
        if ($urandom_range(0, 9) == 0)
          pending_items.push_back(mk_pixel($urandom_range(0, 65535),
                                           $urandom_range(0, 65535)));
        else if ($urandom_range(0, 3) == 0)
          pending_items.push_back(mk_pixel(vx[0] == 0 ? x0 : x0 + rnd_coord(sp) / 16 * 16,
                                           y0 + rnd_coord(sp) / 16 * 16));
        else
          pending_items.push_back(mk_pixel(x0 + rnd_coord(sp), y0 + rnd_coord(sp)));
      end
    end
    stim_done = 1;
  end

  // prediction follows acceptance order, so it uses its own copy of state
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(negedge clk_i) begin : drv
    item_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else begin
          it = pending_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= it.kind;
          s_axis_tdata_i  <= it.data;
          send_gap = rand_gap();
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        recv_gap = rand_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      predict_coverage('{kind: s_axis_tuser_i, data: s_axis_tdata_i});
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0)
        report_mismatch("unexpected", m_axis_tdata_o, '0);
      else begin
        logic [OutDataW-1:0] e;
        e = expected_results.pop_front();
        if (m_axis_tdata_o[0] !== e[0]) report_mismatch("inside_res", m_axis_tdata_o, e);
        if (m_axis_tdata_o[18:1] !== e[18:1]) report_mismatch("bary_0", m_axis_tdata_o, e);
        if (m_axis_tdata_o[36:19] !== e[36:19]) report_mismatch("bary_1", m_axis_tdata_o, e);
        if (m_axis_tdata_o[54:37] !== e[54:37]) report_mismatch("bary_2", m_axis_tdata_o, e);
        if (m_axis_tdata_o[55] !== e[55]) report_mismatch("zero_sum", m_axis_tdata_o, e);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_items.size() > 0 || s_axis_tvalid_i || expected_results.size() > 0) begin
      @(posedge clk_i);
      if (cycles > 200000) begin
        $display("FAILURE");
        $finish;
      end
    end
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
